>>> design/lxc_pkg.sv
// shared types and fixed-point constants for the lda exchange-correlation block
package lxc_pkg;

    localparam int LXC_FRAC_BITS = 24;

    // shared arithmetic unit request and response
    typedef struct packed {
        logic        start;
        logic        div;
        logic [63:0] a;
        logic [63:0] b;
    } t_arith_req;

    typedef struct packed {
        logic         done;
        logic [127:0] res;
    } t_arith_rsp;

    // Q32 constants
    localparam logic [63:0] LXC_Q_ONE = 64'h0000_0001_0000_0000;
    localparam logic signed [63:0] LXC_K_A    = -64'sd611173846;
    localparam logic signed [63:0] LXC_K_B    = 64'sd4522171066;
    localparam logic signed [63:0] LXC_K_C    = 64'sd1431942096;
    localparam logic signed [63:0] LXC_K_SA   = 64'sd133573483;
    localparam logic signed [63:0] LXC_K_SB   = -64'sd206158430;
    localparam logic signed [63:0] LXC_K_SC   = 64'sd8589935;
    localparam logic signed [63:0] LXC_K_SD   = -64'sd49821621;
    localparam logic signed [63:0] LXC_K_B76  = 64'sd5275866244;
    localparam logic signed [63:0] LXC_K_C43  = 64'sd1909256128;
    localparam logic signed [63:0] LXC_K_L1   = -64'sd36077725;
    localparam logic signed [63:0] LXC_K_L2   = -64'sd250682924;
    localparam logic signed [63:0] LXC_K_L3   = 64'sd5726623;
    localparam logic signed [63:0] LXC_K_AX   = -64'sd1967804951;
    localparam logic signed [63:0] LXC_K_AX43 = -64'sd2623739934;
    localparam logic signed [63:0] LXC_K_C3   = 64'sd2664385070;
    localparam logic signed [63:0] LXC_K_LN2  = 64'sd2977044472;

    localparam logic [15:0] LXC_FLOOR_RST = 16'd0;
    localparam logic signed [31:0] LXC_NEG_LIMIT_RST = -32'sd1677722;

    localparam logic [0:0] LXC_REG_FLOOR     = 1'b0;
    localparam logic [0:0] LXC_REG_NEG_LIMIT = 1'b1;

endpackage

>>> design/lxc_arith.sv
// shared multiplier (four 32x32 partial products) and restoring fractional divider
module lxc_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lxc_pkg::t_arith_req i_req,
    output lxc_pkg::t_arith_rsp o_rsp
);
    import lxc_pkg::*;

    localparam logic [6:0] MUL_LAST = 7'd3;
    localparam logic [6:0] DIV_LAST = 7'd95;

    logic         r_busy;
    logic         r_done;
    logic         r_div;
    logic [6:0]   r_cnt;
    logic [63:0]  r_a;
    logic [63:0]  r_b;
    logic         r_dz;
    logic [127:0] r_acc;
    logic [64:0]  r_rem;
    logic [95:0]  r_dq;

    logic [31:0]  w_asel;
    logic [31:0]  w_bsel;
    logic [63:0]  w_pp;
    logic [1:0]   w_k;
    logic [127:0] w_pp_sh;
    logic [64:0]  w_trial;
    logic         w_qbit;
    logic [64:0]  w_rem_nx;

    always_comb begin
        w_asel   = r_cnt[1] ? r_a[63:32] : r_a[31:0];
        w_bsel   = r_cnt[0] ? r_b[63:32] : r_b[31:0];
        w_pp     = w_asel * w_bsel;
        w_k      = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
        w_pp_sh  = {64'd0, w_pp} << {w_k, 5'd0};
        // one quotient bit per step
        w_trial  = {r_rem[63:0], r_dq[95]};
        w_qbit   = w_trial >= {1'b0, r_b};
        w_rem_nx = w_qbit ? w_trial - {1'b0, r_b} : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_div  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_div  <= i_req.div;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if ((r_div && r_cnt == DIV_LAST) || (!r_div && r_cnt == MUL_LAST)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_b   <= i_req.b;
            r_dz  <= (i_req.b == 64'd0);
            r_acc <= '0;
            r_rem <= '0;
            r_dq  <= {i_req.a, 32'd0};
        end else if (r_busy) begin
            if (r_div) begin
                r_rem <= w_rem_nx;
                r_dq  <= {r_dq[94:0], w_qbit};
            end else begin
                r_acc <= r_acc + w_pp_sh;
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        if (!r_div) begin
            o_rsp.res = r_acc;
        end else if (r_dz) begin
            o_rsp.res = {64'd0, {64{1'b1}}};
        end else begin
            o_rsp.res = {64'd0, r_dq[63:0]};
        end
    end

endmodule

>>> design/lda_xc_perdew_zunger.sv
// top level: perdew-zunger lda exchange-correlation potential and energy sum
// A density request enters on i_in_valid/o_in_ready; o_in_ready is high only
// while the sequencer is idle. Each result leaves on o_out_valid/i_out_ready
// from an output register, so the next request is taken while a result waits.
// Configuration writes (i_cfg_we, i_cfg_addr, i_cfg_data) take effect at once
// and are expected only while no request is in flight.
// A vacuum or negative density skips the computation and goes straight to the
// final step. Other densities run the log form (rs below 1) or the pade form;
// the cube root loop (38 bits, three products each), the 96-step divides
// (three in log form, five in pade form) and the square root or log loop
// dominate. All products run on one 32x32 multiplier, all quotients on one
// bit-per-cycle divider, so one request is in flight at a time.
// A result that is not taken holds the sequencer in its final step until the
// receiver accepts it; nothing is dropped.
// Reset clears the energy sum, restores the register defaults and empties the
// output register. The energy sum is cleared after the request marked last.
module lda_xc_perdew_zunger #(
    parameter int FRAC_BITS = lxc_pkg::LXC_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_density,
    input  logic        i_last_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_potential,
    output logic [47:0] o_energy_sum,
    output logic        o_negative_warning,
    output logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);
    import lxc_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CB1  = 5'd1;
    localparam logic [4:0] S_CB2  = 5'd2;
    localparam logic [4:0] S_CB3  = 5'd3;
    localparam logic [4:0] S_RS   = 5'd4;
    localparam logic [4:0] S_EX   = 5'd5;
    localparam logic [4:0] S_UX   = 5'd6;
    localparam logic [4:0] S_SQ   = 5'd7;
    localparam logic [4:0] S_P1   = 5'd8;
    localparam logic [4:0] S_P2   = 5'd9;
    localparam logic [4:0] S_P3   = 5'd10;
    localparam logic [4:0] S_P4   = 5'd11;
    localparam logic [4:0] S_P5   = 5'd12;
    localparam logic [4:0] S_P6   = 5'd13;
    localparam logic [4:0] S_P7   = 5'd14;
    localparam logic [4:0] S_LNZ  = 5'd15;
    localparam logic [4:0] S_LNM  = 5'd16;
    localparam logic [4:0] S_LNF  = 5'd17;
    localparam logic [4:0] S_L1   = 5'd18;
    localparam logic [4:0] S_L2   = 5'd19;
    localparam logic [4:0] S_L3   = 5'd20;
    localparam logic [4:0] S_L4   = 5'd21;
    localparam logic [4:0] S_L5   = 5'd22;
    localparam logic [4:0] S_L6   = 5'd23;
    localparam logic [4:0] S_TERM = 5'd24;
    localparam logic [4:0] S_SUM  = 5'd25;

    // operation kinds of the shared unit
    localparam logic [2:0] K_NONE = 3'd0;
    localparam logic [2:0] K_UMUL = 3'd1;
    localparam logic [2:0] K_UDIV = 3'd2;
    localparam logic [2:0] K_QM   = 3'd3;
    localparam logic [2:0] K_TM   = 3'd4;
    localparam logic [2:0] K_SDIV = 3'd5;

    localparam int RHO_SH  = 32 - FRAC_BITS;
    localparam int TERM_SH = 64 - FRAC_BITS;
    localparam logic [5:0] TOP_BIT = 6'd37;
    localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] SUM_MAX = 65'sd140737488355327;
    localparam logic signed [64:0] SUM_MIN = -65'sd140737488355328;

    logic [4:0]   r_state;
    logic         r_issued;
    logic [15:0]  r_floor;
    logic [31:0]  r_neg_limit;
    logic [47:0]  r_acc;
    logic [63:0]  r_rho;
    logic [63:0]  r_y;
    logic [5:0]   r_bit;
    logic [127:0] r_w;
    logic [127:0] r_w2;
    logic [63:0]  r_rs;
    logic [63:0]  r_ex;
    logic [63:0]  r_ux;
    logic [63:0]  r_ec;
    logic [63:0]  r_uc;
    logic [63:0]  r_bpr;
    logic [63:0]  r_num;
    logic [63:0]  r_rsl;
    logic [63:0]  r_rr;
    logic [31:0]  r_m;
    logic [4:0]   r_p;
    logic [4:0]   r_i;
    logic [31:0]  r_frac;
    logic [63:0]  r_term;
    logic [31:0]  r_pot;
    logic         r_warn;
    logic         r_last;
    logic         r_out_valid;
    logic [31:0]  r_o_pot;
    logic [47:0]  r_o_sum;
    logic         r_o_warn;
    logic         r_o_last;

    t_arith_req   w_req;
    t_arith_rsp   w_rsp;
    logic [2:0]   w_kind;
    logic [63:0]  w_opa;
    logic [63:0]  w_opb;
    logic         w_signed;
    logic         w_neg;
    logic [63:0]  w_maga;
    logic [63:0]  w_magb;
    logic [127:0] w_sum32;
    logic [127:0] w_sums;
    logic [127:0] w_shs;
    logic [63:0]  w_m;
    logic [63:0]  w_msat;
    logic [63:0]  w_res;
    logic [63:0]  w_t;
    logic [127:0] w_cube;
    logic [32:0]  w_mm;
    logic [63:0]  w_v;
    logic [63:0]  w_vmag;
    logic [64:0]  w_vm;
    logic [31:0]  w_pot;
    logic signed [64:0] w_sum;
    logic [47:0]  w_sum_sat;
    logic         w_load;
    logic         w_go;

    lxc_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_t = r_y | (64'd1 << r_bit);

    // operand selection per sequencer step
    always_comb begin
        w_kind = K_NONE;
        w_opa  = '0;
        w_opb  = '0;
        unique case (r_state)
            S_CB1:  begin w_kind = K_UMUL; w_opa = w_t;         w_opb = w_t;  end
            S_CB2:  begin w_kind = K_UMUL; w_opa = r_w[63:0];   w_opb = w_t;  end
            S_CB3:  begin w_kind = K_UMUL; w_opa = r_w[127:64]; w_opb = w_t;  end
            S_RS:   begin w_kind = K_UDIV; w_opa = LXC_K_C3;    w_opb = r_y;  end
            S_EX:   begin w_kind = K_SDIV; w_opa = LXC_K_AX;    w_opb = r_rs; end
            S_UX:   begin w_kind = K_SDIV; w_opa = LXC_K_AX43;  w_opb = r_rs; end
            S_SQ:   begin w_kind = K_UMUL; w_opa = w_t;         w_opb = w_t;  end
            S_P1:   begin w_kind = K_QM;   w_opa = LXC_K_B;     w_opb = r_y;  end
            S_P2:   begin w_kind = K_QM;   w_opa = LXC_K_C;     w_opb = r_rs; end
            S_P3:   begin w_kind = K_QM;   w_opa = LXC_K_B76;   w_opb = r_y;  end
            S_P4:   begin w_kind = K_QM;   w_opa = LXC_K_C43;   w_opb = r_rs; end
            S_P5:   begin w_kind = K_SDIV; w_opa = LXC_K_A;     w_opb = r_bpr; end
            S_P6:   begin w_kind = K_QM;   w_opa = r_num;       w_opb = r_ec; end
            S_P7:   begin w_kind = K_SDIV; w_opa = r_num;       w_opb = r_bpr; end
            S_LNM:  begin w_kind = K_UMUL; w_opa = {32'd0, r_m}; w_opb = {32'd0, r_m}; end
            S_LNF:  begin
                w_kind = K_QM;
                w_opa  = {27'h7FF_FFFF, r_p, r_frac};
                w_opb  = LXC_K_LN2;
            end
            S_L1:   begin w_kind = K_QM;   w_opa = r_rs;        w_opb = r_rsl; end
            S_L2:   begin w_kind = K_QM;   w_opa = LXC_K_SA;    w_opb = r_rsl; end
            S_L3:   begin w_kind = K_QM;   w_opa = LXC_K_SC;    w_opb = r_rr; end
            S_L4:   begin w_kind = K_QM;   w_opa = LXC_K_SD;    w_opb = r_rs; end
            S_L5:   begin w_kind = K_QM;   w_opa = LXC_K_L1;    w_opb = r_rs; end
            S_L6:   begin w_kind = K_QM;   w_opa = LXC_K_L3;    w_opb = r_rr; end
            S_TERM: begin w_kind = K_TM;   w_opa = r_rho;       w_opb = r_ex + r_ec; end
            default: begin w_kind = K_NONE; end
        endcase
    end

    always_comb begin
        w_signed = (w_kind == K_QM) || (w_kind == K_TM) || (w_kind == K_SDIV);
        w_neg    = w_opa[63] ^ w_opb[63];
        w_maga   = (w_signed && w_opa[63]) ? 64'd0 - w_opa : w_opa;
        w_magb   = (w_signed && w_opb[63]) ? 64'd0 - w_opb : w_opb;

        w_req.start = (w_kind != K_NONE) && !r_issued;
        w_req.div   = (w_kind == K_UDIV) || (w_kind == K_SDIV);
        w_req.a     = w_maga;
        w_req.b     = w_magb;

        // signed products round half away from zero on the magnitude; signed results then saturate and take their sign
        w_sum32 = w_rsp.res + 128'h8000_0000;
        w_sums  = w_rsp.res + (128'd1 << (TERM_SH - 1));
        w_shs   = w_sums >> TERM_SH;
        if (w_kind == K_QM) begin
            w_m = w_sum32[95:32];
        end else if (w_kind == K_TM) begin
            w_m = w_shs[63:0];
        end else begin
            w_m = w_rsp.res[63:0];
        end
        w_msat = w_m[63] ? I64_MAX : w_m;
        if (w_signed) begin
            w_res = w_neg ? 64'd0 - w_msat : w_msat;
        end else begin
            w_res = w_rsp.res[63:0];
        end

        w_cube = r_w2 + {w_rsp.res[63:0], 64'd0};
        w_mm   = w_rsp.res[63:31];

        w_v    = r_ux + r_uc;
        w_vmag = w_v[63] ? 64'd0 - w_v : w_v;
        w_vm   = ({1'b0, w_vmag} + (65'd1 << (31 - FRAC_BITS))) >> RHO_SH;
        if (!w_v[63]) begin
            w_pot = (w_vm > 65'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w_vm[31:0];
        end else begin
            w_pot = (w_vm > 65'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - w_vm[31:0];
        end

        w_sum = {{17{r_acc[47]}}, r_acc} + {r_term[63], r_term};
        if (w_sum > SUM_MAX) begin
            w_sum_sat = SUM_MAX[47:0];
        end else if (w_sum < SUM_MIN) begin
            w_sum_sat = SUM_MIN[47:0];
        end else begin
            w_sum_sat = w_sum[47:0];
        end

        w_load = (r_state == S_SUM) && (!r_out_valid || i_out_ready);
        w_go   = i_in_valid && (r_state == S_IDLE);
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor     <= LXC_FLOOR_RST;
            r_neg_limit <= LXC_NEG_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                LXC_REG_FLOOR:     r_floor     <= i_cfg_data[15:0];
                LXC_REG_NEG_LIMIT: r_neg_limit <= i_cfg_data;
                default:           r_floor     <= r_floor;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_req.start) begin
                r_issued <= 1'b1;
            end else if (w_rsp.done) begin
                r_issued <= 1'b0;
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
                r_acc       <= r_last ? 48'd0 : w_sum_sat;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_go) begin
                        if ($signed(i_density) < $signed(r_neg_limit)) begin
                            r_state <= S_SUM;
                        end else if ($signed(i_density) <= $signed({16'd0, r_floor})) begin
                            r_state <= S_SUM;
                        end else begin
                            r_state <= S_CB1;
                        end
                    end
                end
                S_CB1:  if (w_rsp.done) r_state <= S_CB2;
                S_CB2:  if (w_rsp.done) r_state <= S_CB3;
                S_CB3:  if (w_rsp.done) r_state <= (r_bit == 6'd0) ? S_RS : S_CB1;
                S_RS:   if (w_rsp.done) r_state <= S_EX;
                S_EX:   if (w_rsp.done) r_state <= S_UX;
                S_UX: begin
                    if (w_rsp.done) begin
                        r_state <= ($signed(r_rs) >= $signed(LXC_Q_ONE)) ? S_SQ : S_LNZ;
                    end
                end
                S_SQ:   if (w_rsp.done) r_state <= (r_bit == 6'd0) ? S_P1 : S_SQ;
                S_P1:   if (w_rsp.done) r_state <= S_P2;
                S_P2:   if (w_rsp.done) r_state <= S_P3;
                S_P3:   if (w_rsp.done) r_state <= S_P4;
                S_P4:   if (w_rsp.done) r_state <= S_P5;
                S_P5:   if (w_rsp.done) r_state <= S_P6;
                S_P6:   if (w_rsp.done) r_state <= S_P7;
                S_P7:   if (w_rsp.done) r_state <= S_TERM;
                S_LNZ:  if (r_p == 5'd0 || r_m[31]) r_state <= S_LNM;
                S_LNM:  if (w_rsp.done && r_i == 5'd0) r_state <= S_LNF;
                S_LNF:  if (w_rsp.done) r_state <= S_L1;
                S_L1:   if (w_rsp.done) r_state <= S_L2;
                S_L2:   if (w_rsp.done) r_state <= S_L3;
                S_L3:   if (w_rsp.done) r_state <= S_L4;
                S_L4:   if (w_rsp.done) r_state <= S_L5;
                S_L5:   if (w_rsp.done) r_state <= S_L6;
                S_L6:   if (w_rsp.done) r_state <= S_TERM;
                S_TERM: if (w_rsp.done) r_state <= S_SUM;
                S_SUM:  if (w_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_last <= i_last_sample;
                r_warn <= $signed(i_density) < $signed(r_neg_limit);
                r_term <= '0;
                r_pot  <= '0;
                r_rho  <= {32'd0, i_density} << RHO_SH;
                r_y    <= '0;
                r_bit  <= TOP_BIT;
            end
            S_CB1: if (w_rsp.done) r_w  <= w_rsp.res;
            S_CB2: if (w_rsp.done) r_w2 <= w_rsp.res;
            S_CB3: begin
                if (w_rsp.done) begin
                    // keep the trial bit while its cube stays within rho
                    if (w_cube <= {r_rho, 64'd0}) r_y <= w_t;
                    r_bit <= r_bit - 6'd1;
                end
            end
            S_RS: begin
                if (w_rsp.done) begin
                    r_rs <= w_res;
                    r_y  <= '0;
                end
            end
            S_EX: if (w_rsp.done) r_ex <= w_res;
            S_UX: begin
                if (w_rsp.done) begin
                    r_ux   <= w_res;
                    r_bit  <= TOP_BIT;
                    r_m    <= r_rs[31:0];
                    r_p    <= 5'd31;
                    r_i    <= 5'd31;
                    r_frac <= '0;
                end
            end
            S_SQ: begin
                if (w_rsp.done) begin
                    if (w_rsp.res <= {32'd0, r_rs, 32'd0}) r_y <= w_t;
                    r_bit <= r_bit - 6'd1;
                end
            end
            S_P1: if (w_rsp.done) r_bpr <= LXC_Q_ONE + w_res;
            S_P2: if (w_rsp.done) r_bpr <= r_bpr + w_res;
            S_P3: if (w_rsp.done) r_num <= LXC_Q_ONE + w_res;
            S_P4: if (w_rsp.done) r_num <= r_num + w_res;
            S_P5: if (w_rsp.done) r_ec  <= w_res;
            S_P6: if (w_rsp.done) r_num <= w_res;
            S_P7: if (w_rsp.done) r_uc  <= w_res;
            S_LNZ: begin
                // bring the leading one to bit 31
                if (r_p != 5'd0 && !r_m[31]) begin
                    r_m <= {r_m[30:0], 1'b0};
                    r_p <= r_p - 5'd1;
                end
            end
            S_LNM: begin
                if (w_rsp.done) begin
                    if (w_mm[32]) begin
                        r_m         <= w_mm[32:1];
                        r_frac[r_i] <= 1'b1;
                    end else begin
                        r_m <= w_mm[31:0];
                    end
                    r_i <= r_i - 5'd1;
                end
            end
            S_LNF: if (w_rsp.done) r_rsl <= w_res;
            S_L1:  if (w_rsp.done) r_rr  <= w_res;
            S_L2: begin
                if (w_rsp.done) begin
                    r_num <= w_res;
                    r_ec  <= w_res + LXC_K_SB;
                end
            end
            S_L3: if (w_rsp.done) r_ec <= r_ec + w_res;
            S_L4: if (w_rsp.done) r_ec <= r_ec + w_res;
            S_L5: if (w_rsp.done) r_uc <= w_res + LXC_K_L2 + r_num;
            S_L6: if (w_rsp.done) r_uc <= r_uc + w_res;
            S_TERM: begin
                if (w_rsp.done) begin
                    r_term <= w_res;
                    r_pot  <= w_pot;
                end
            end
            default: begin
                r_last <= r_last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_pot  <= r_pot;
            r_o_sum  <= w_sum_sat;
            r_o_warn <= r_warn;
            r_o_last <= r_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_potential        = r_o_pot;
    assign o_energy_sum       = r_o_sum;
    assign o_negative_warning = r_o_warn;
    assign o_last_result      = r_o_last;

endmodule
